>>> rtl/stt_pkg.sv
// Shared types and codes for the task timer table.
`timescale 1ns / 1ps

package stt_pkg;

   localparam int SLOTS        = 8;
   localparam int TASK_ID_BITS = 8;

   localparam int REQ_W   = 3;
   localparam int KIND_W  = 3;
   localparam int ID_W    = 8;
   localparam int TIME_W  = 32;
   localparam int SLOT_W  = 3;
   localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PERIOD_W = 16;

   typedef logic [REQ_W-1:0]        req_code_type;
   typedef logic [KIND_W-1:0]       kind_type;
   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic [TASK_ID_BITS-1:0] task_type;
   typedef logic [ID_W-1:0]         id_port_type;
   typedef logic [TIME_W-1:0]       time_type;
   typedef logic [SLOT_W-1:0]       slot_port_type;

   localparam req_code_type REQ_ADD    = 3'd0;
   localparam req_code_type REQ_DELETE = 3'd1;
   localparam req_code_type REQ_QUERY  = 3'd2;
   localparam req_code_type REQ_TICK   = 3'd3;
   localparam req_code_type REQ_INSERT = 3'd4;

   localparam kind_type KIND_ADDED   = 3'd0;
   localparam kind_type KIND_DELETED = 3'd1;
   localparam kind_type KIND_QUERY   = 3'd2;
   localparam kind_type KIND_FIRED   = 3'd3;
   localparam kind_type KIND_SLEEP   = 3'd4;

   localparam idx_type  LAST_IDX = idx_type'(SLOTS - 1);
   localparam time_type ALL_ONES = '1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         load;
      logic         step1;
      logic         step2;
      logic         emit_final;
      idx_type      idx;
      req_code_type op;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic fire;
   } sts_type;

endpackage

>>> rtl/stt_ctrl.sv
// Controller: request state machine and slot walk counter.
`timescale 1ns / 1ps

module stt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  stt_pkg::req_code_type req_type,
   input  stt_pkg::sts_type     sts,
   output stt_pkg::cmd_type     cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_PASS2 = 2'd2;
   localparam logic [1:0] ST_FINAL = 2'd3;

   logic [1:0]            state_ff, state_in;
   stt_pkg::idx_type      idx_ff, idx_in;
   stt_pkg::req_code_type op_ff, op_in;
   logic                  accept;
   logic                  known;
   logic                  stall;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign known     = (req_type == stt_pkg::REQ_ADD) || (req_type == stt_pkg::REQ_DELETE) ||
                      (req_type == stt_pkg::REQ_QUERY) || (req_type == stt_pkg::REQ_TICK) ||
                      (req_type == stt_pkg::REQ_INSERT);
   // hold the walk while a fired word cannot be placed in the output register
   assign stall     = (op_ff == stt_pkg::REQ_TICK) && sts.fire && !sts.out_free;

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      op_in           = op_ff;
      cmd.load        = 1'b0;
      cmd.step1       = 1'b0;
      cmd.step2       = 1'b0;
      cmd.emit_final  = 1'b0;
      cmd.idx         = idx_ff;
      cmd.op          = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               op_in    = req_type;
               idx_in   = '0;
               state_in = known ? ST_WALK : ST_FINAL;
            end
         end
         ST_WALK: begin
            if (!stall) begin
               cmd.step1 = 1'b1;
               if (idx_ff == stt_pkg::LAST_IDX) begin
                  idx_in   = '0;
                  state_in = (op_ff == stt_pkg::REQ_TICK) ? ST_PASS2 : ST_FINAL;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_PASS2: begin
            cmd.step2 = 1'b1;
            if (idx_ff == stt_pkg::LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_FINAL;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_FINAL: begin
            if (sts.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         op_ff    <= stt_pkg::REQ_ADD;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         op_ff    <= op_in;
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted request did not start work");

   a_pass2_only_tick: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PASS2 |-> op_ff == stt_pkg::REQ_TICK)
      else $error("second pass entered for a request that is not a tick");

   a_final_idx_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINAL |-> idx_ff == '0)
      else $error("slot counter not rewound before the final word");

endmodule

>>> rtl/stt_dp.sv
// Datapath: slot table, walk accumulators and output register.
`timescale 1ns / 1ps

module stt_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  stt_pkg::cmd_type      cmd,
   output stt_pkg::sts_type      sts,
   input  stt_pkg::req_code_type req_type,
   input  stt_pkg::id_port_type  req_task_id,
   input  stt_pkg::time_type     req_timeout_value,
   input  logic                  csr_valid,
   input  stt_pkg::time_type     csr_min_sleep_threshold,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output stt_pkg::kind_type     rsp_result_kind,
   output stt_pkg::slot_port_type rsp_slot_index,
   output logic                  rsp_table_full,
   output stt_pkg::id_port_type  rsp_fired_id,
   output stt_pkg::time_type     rsp_result_value,
   output logic                  rsp_last
);

   logic [stt_pkg::SLOTS-1:0] used_ff;
   stt_pkg::time_type         time_ff [stt_pkg::SLOTS];
   stt_pkg::task_type         task_ff [stt_pkg::SLOTS];

   stt_pkg::time_type thr_ff;
   stt_pkg::time_type pending_ff;
   stt_pkg::task_type id_ff;
   stt_pkg::time_type tmo_ff;
   stt_pkg::time_type add_diff_ff, add_diff_in;
   stt_pkg::time_type new_time_ff, new_time_in;
   logic              pend_set_ff, pend_set_in;
   logic              found_ff;
   stt_pkg::idx_type  slot_ff;
   stt_pkg::time_type least_ff;
   stt_pkg::time_type q_ff;

   logic                  valid_ff;
   stt_pkg::kind_type     kind_ff;
   stt_pkg::slot_port_type slot_out_ff;
   logic                  full_ff;
   stt_pkg::id_port_type  fired_ff;
   stt_pkg::time_type     value_ff;
   logic                  last_ff;

   logic              cur_used;
   stt_pkg::time_type cur_time;
   stt_pkg::task_type cur_task;
   logic              hit;
   logic              fire;
   logic              add_like;
   logic              is_tick;
   logic              emit_fire;
   logic              out_free;
   logic              in_window;
   stt_pkg::time_type sub_val;

   assign cur_used  = used_ff[cmd.idx];
   assign cur_time  = time_ff[cmd.idx];
   assign cur_task  = task_ff[cmd.idx];
   assign hit       = cur_used && (cur_task == id_ff);
   assign fire      = cur_used && (cur_time == '0);
   assign add_like  = (cmd.op == stt_pkg::REQ_ADD) || (cmd.op == stt_pkg::REQ_INSERT);
   assign is_tick   = (cmd.op == stt_pkg::REQ_TICK);
   assign emit_fire = cmd.step1 && is_tick && fire;
   assign out_free  = !valid_ff || rsp_ready;
   assign sub_val   = cur_time - least_ff;

   assign sts.out_free = out_free;
   assign sts.fire     = fire;

   // insert inside the pending sleep window: shift others, start the new task at zero
   always_comb begin
      in_window   = (pending_ff != '0) && (pending_ff > req_timeout_value);
      pend_set_in = (req_type == stt_pkg::REQ_INSERT) && in_window;
      add_diff_in = pend_set_in ? (pending_ff - req_timeout_value) : '0;
      if (req_type != stt_pkg::REQ_INSERT || pending_ff == '0) begin
         new_time_in = req_timeout_value;
      end else if (in_window) begin
         new_time_in = '0;
      end else begin
         new_time_in = req_timeout_value - pending_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         pending_ff <= '0;
         thr_ff     <= '0;
         found_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            thr_ff <= csr_min_sleep_threshold;
         end
         if (cmd.load) begin
            found_ff <= 1'b0;
         end
         if (cmd.step1) begin
            if ((add_like || cmd.op == stt_pkg::REQ_DELETE) && hit) begin
               used_ff[cmd.idx] <= 1'b0;
            end
            if (emit_fire) begin
               used_ff[cmd.idx] <= 1'b0;
            end
            if (add_like && !found_ff && (!cur_used || hit)) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.emit_final) begin
            if (add_like && found_ff) begin
               used_ff[slot_ff] <= 1'b1;
            end
            if (is_tick) begin
               pending_ff <= stt_pkg::time_type'(least_ff[stt_pkg::PERIOD_W-1:0]);
            end else if (add_like && pend_set_ff) begin
               pending_ff <= tmo_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff       <= req_task_id[stt_pkg::TASK_ID_BITS-1:0];
         tmo_ff      <= req_timeout_value;
         add_diff_ff <= add_diff_in;
         new_time_ff <= new_time_in;
         pend_set_ff <= pend_set_in;
         least_ff    <= stt_pkg::ALL_ONES;
         q_ff        <= '0;
      end
      if (cmd.step1) begin
         if (add_like && cur_used) begin
            time_ff[cmd.idx] <= cur_time + add_diff_ff;
         end
         if (add_like && !found_ff && (!cur_used || hit)) begin
            slot_ff <= cmd.idx;
         end
         if (cmd.op == stt_pkg::REQ_QUERY && hit) begin
            q_ff <= cur_time;
         end
         if (is_tick && cur_used && !fire && cur_time < least_ff) begin
            least_ff <= cur_time;
         end
      end
      if (cmd.step2 && cur_used) begin
         time_ff[cmd.idx] <= (sub_val < thr_ff) ? '0 : sub_val;
      end
      if (cmd.emit_final && add_like && found_ff) begin
         time_ff[slot_ff] <= new_time_ff;
         task_ff[slot_ff] <= id_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (emit_fire || cmd.emit_final) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         kind_ff     <= stt_pkg::KIND_FIRED;
         slot_out_ff <= '0;
         full_ff     <= 1'b0;
         fired_ff    <= stt_pkg::id_port_type'(cur_task);
         value_ff    <= '0;
         last_ff     <= 1'b0;
      end else if (cmd.emit_final) begin
         slot_out_ff <= '0;
         full_ff     <= 1'b0;
         fired_ff    <= '0;
         value_ff    <= '0;
         last_ff     <= 1'b1;
         priority case (1'b1)
            add_like: begin
               kind_ff     <= stt_pkg::KIND_ADDED;
               full_ff     <= !found_ff;
               slot_out_ff <= found_ff ? stt_pkg::slot_port_type'(slot_ff) : '0;
            end
            (cmd.op == stt_pkg::REQ_QUERY): begin
               kind_ff  <= stt_pkg::KIND_QUERY;
               value_ff <= q_ff;
            end
            is_tick: begin
               kind_ff  <= stt_pkg::KIND_SLEEP;
               value_ff <= stt_pkg::time_type'(least_ff[stt_pkg::PERIOD_W-1:0]);
            end
            default: begin
               kind_ff <= stt_pkg::KIND_DELETED;
            end
         endcase
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_slot_index   = slot_out_ff;
   assign rsp_table_full   = full_ff;
   assign rsp_fired_id     = fired_ff;
   assign rsp_result_value = value_ff;
   assign rsp_last         = last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (emit_fire || cmd.emit_final) |-> out_free)
      else $error("result word written over one not yet taken");

   a_pending_narrow: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_final && is_tick) |=> pending_ff[stt_pkg::TIME_W-1:stt_pkg::PERIOD_W] == '0)
      else $error("sleep window wider than the reported period");

   a_slot_taken: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_final && add_like && found_ff) |=> used_ff[$past(slot_ff)])
      else $error("added task did not occupy its slot");

endmodule

>>> rtl/software_timer_task_table_top.sv
// Top level of the one-shot task timer table.
`timescale 1ns / 1ps

// Table of one-shot task timers with a request channel, a response channel and
// one control register (min_sleep_threshold) written through the csr_ port.
// A request word is taken when req_valid and req_ready are high at a clock edge;
// req_ready is high only while no request is in work. Add, insert, delete and
// query walk the table once, one slot a cycle, and give one response word; an
// unknown request code skips the walk and gives a deleted word. A service tick
// walks twice (fire and find the least time, then subtract and clamp), sending
// one word per fired slot during the first walk and the sleep period word
// (rsp_last high) after the second. Each request ends with the final state and
// a return to idle, in which the next request is taken. A response sits in the
// output register until rsp_ready; a stalled receiver holds the walk only when
// the next fired word or the final word has nowhere to go, and the next request
// may be accepted while the last word still waits.
// csr_ready is always high. Synchronous reset empties the table, clears the
// pending sleep window and the threshold; no clearing pass is needed.

module software_timer_task_table_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  stt_pkg::req_code_type  req_type,
   input  stt_pkg::id_port_type   req_task_id,
   input  stt_pkg::time_type      req_timeout_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output stt_pkg::kind_type      rsp_result_kind,
   output stt_pkg::slot_port_type rsp_slot_index,
   output logic                   rsp_table_full,
   output stt_pkg::id_port_type   rsp_fired_id,
   output stt_pkg::time_type      rsp_result_value,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  stt_pkg::time_type      csr_min_sleep_threshold
);

   stt_pkg::cmd_type cmd;
   stt_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   stt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .sts       (sts),
      .cmd       (cmd)
   );

   stt_dp u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .sts                     (sts),
      .req_type                (req_type),
      .req_task_id             (req_task_id),
      .req_timeout_value       (req_timeout_value),
      .csr_valid               (csr_valid),
      .csr_min_sleep_threshold (csr_min_sleep_threshold),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_result_kind         (rsp_result_kind),
      .rsp_slot_index          (rsp_slot_index),
      .rsp_table_full          (rsp_table_full),
      .rsp_fired_id            (rsp_fired_id),
      .rsp_result_value        (rsp_result_value),
      .rsp_last                (rsp_last)
   );

endmodule

>>> verif/software_timer_task_table_top_tb.sv
// Self-checking testbench for the one-shot task timer table.
`timescale 1ns / 1ps

module software_timer_task_table_top_tb;

   localparam int WALK_CYCLES  = 2 * stt_pkg::SLOTS + 4;
   localparam int REPORT_LIMIT = 10;
   localparam int ID_POOL      = 12;
   localparam stt_pkg::req_code_type REQ_UNUSED_FIRST =
      stt_pkg::req_code_type'(stt_pkg::REQ_INSERT + 3'd1);
   localparam stt_pkg::req_code_type REQ_UNUSED_LAST  = '1;
   localparam stt_pkg::time_type WRAP_STEP = 32'h0001_0000;

   typedef struct packed {
      stt_pkg::kind_type      kind;
      stt_pkg::slot_port_type slot;
      logic                   full;
      stt_pkg::id_port_type   fired;
      stt_pkg::time_type      value;
      logic                   last;
   } timer_word_type;

   // Tracks the timer table and holds the response words still owed.
   class task_table_checker;
      bit                 used [stt_pkg::SLOTS];
      stt_pkg::time_type  remaining [stt_pkg::SLOTS];
      stt_pkg::task_type  owner [stt_pkg::SLOTS];
      stt_pkg::time_type  sleep_window = '0;
      stt_pkg::time_type  threshold = '0;
      timer_word_type     expected_words [$];
      int                 errors = 0;
      int                 requests_seen = 0;
      int                 words_seen = 0;
      int                 fired_seen = 0;
      int                 full_seen = 0;

      function new();
         foreach (used[i]) begin
            used[i]      = 1'b0;
            remaining[i] = '0;
            owner[i]     = '0;
         end
      endfunction

      function void free_id(stt_pkg::task_type id);
         foreach (used[i])
            if (used[i] && owner[i] == id)
               used[i] = 1'b0;
      endfunction

      // Returns the slot taken, or -1 when the table is full.
      function int place_task(stt_pkg::task_type id, stt_pkg::time_type t);
         free_id(id);
         foreach (used[i]) begin
            if (!used[i]) begin
               used[i]      = 1'b1;
               remaining[i] = t;
               owner[i]     = id;
               return i;
            end
         end
         return -1;
      endfunction

      function void push_word(stt_pkg::kind_type kind, int slot, logic full,
                              stt_pkg::id_port_type fired, stt_pkg::time_type value,
                              logic last);
         timer_word_type w;
         w.kind  = kind;
         w.slot  = stt_pkg::slot_port_type'(slot);
         w.full  = full;
         w.fired = fired;
         w.value = value;
         w.last  = last;
         expected_words.push_back(w);
      endfunction

      function void push_placement(int slot);
         if (slot < 0)
            push_word(stt_pkg::KIND_ADDED, 0, 1'b1, '0, '0, 1'b1);
         else
            push_word(stt_pkg::KIND_ADDED, slot, 1'b0, '0, '0, 1'b1);
      endfunction

      function void note_request(stt_pkg::req_code_type op, stt_pkg::id_port_type id_in,
                                 stt_pkg::time_type tmo);
         stt_pkg::task_type id;
         stt_pkg::time_type least;
         stt_pkg::time_type found;
         id = stt_pkg::task_type'(id_in);
         requests_seen++;
         case (op)
            stt_pkg::REQ_ADD: begin
               push_placement(place_task(id, tmo));
            end
            stt_pkg::REQ_DELETE: begin
               free_id(id);
               push_word(stt_pkg::KIND_DELETED, 0, 1'b0, '0, '0, 1'b1);
            end
            stt_pkg::REQ_QUERY: begin
               found = '0;
               foreach (used[i])
                  if (used[i] && owner[i] == id)
                     found = remaining[i];
               push_word(stt_pkg::KIND_QUERY, 0, 1'b0, '0, found, 1'b1);
            end
            stt_pkg::REQ_TICK: begin
               least = stt_pkg::ALL_ONES;
               foreach (used[i]) begin
                  if (used[i] && remaining[i] == '0) begin
                     used[i] = 1'b0;
                     push_word(stt_pkg::KIND_FIRED, 0, 1'b0,
                               stt_pkg::id_port_type'(owner[i]), '0, 1'b0);
                  end
               end
               foreach (used[i])
                  if (used[i] && remaining[i] != '0 && remaining[i] < least)
                     least = remaining[i];
               foreach (used[i]) begin
                  if (used[i]) begin
                     remaining[i] = remaining[i] - least;
                     if (remaining[i] < threshold)
                        remaining[i] = '0;
                  end
               end
               sleep_window = stt_pkg::time_type'(least[stt_pkg::PERIOD_W-1:0]);
               push_word(stt_pkg::KIND_SLEEP, 0, 1'b0, '0, sleep_window, 1'b1);
            end
            stt_pkg::REQ_INSERT: begin
               if (sleep_window != '0 && sleep_window > tmo) begin
                  // stretch every pending timer by the part of the window cut off
                  foreach (used[i])
                     if (used[i])
                        remaining[i] = remaining[i] + (sleep_window - tmo);
                  sleep_window = tmo;
                  push_placement(place_task(id, '0));
               end else if (sleep_window != '0) begin
                  push_placement(place_task(id, tmo - sleep_window));
               end else begin
                  push_placement(place_task(id, tmo));
               end
            end
            default: begin
               push_word(stt_pkg::KIND_DELETED, 0, 1'b0, '0, '0, 1'b1);
            end
         endcase
      endfunction

      function void check_word(stt_pkg::kind_type kind, stt_pkg::slot_port_type slot,
                               logic full, stt_pkg::id_port_type fired,
                               stt_pkg::time_type value, logic last);
         timer_word_type want;
         words_seen++;
         if (expected_words.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display({"ERROR: unexpected word kind=%0d slot=%0d full=%0b id=%0h ",
                         "value=%0h last=%0b"}, kind, slot, full, fired, value, last);
            return;
         end
         want = expected_words.pop_front();
         if (want.kind == stt_pkg::KIND_FIRED)
            fired_seen++;
         if (want.full)
            full_seen++;
         if (kind !== want.kind || slot !== want.slot || full !== want.full ||
             fired !== want.fired || value !== want.value || last !== want.last) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("ERROR: word mismatch at %0t", $realtime);
               $display("  expected kind=%0d slot=%0d full=%0b id=%0h value=%0h last=%0b",
                        want.kind, want.slot, want.full, want.fired, want.value, want.last);
               $display("  actual   kind=%0d slot=%0d full=%0b id=%0h value=%0h last=%0b",
                        kind, slot, full, fired, value, last);
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   stt_pkg::req_code_type  req_type = stt_pkg::REQ_ADD;
   stt_pkg::id_port_type   req_task_id = '0;
   stt_pkg::time_type      req_timeout_value = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   stt_pkg::kind_type      rsp_result_kind;
   stt_pkg::slot_port_type rsp_slot_index;
   logic                   rsp_table_full;
   stt_pkg::id_port_type   rsp_fired_id;
   stt_pkg::time_type      rsp_result_value;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   stt_pkg::time_type      csr_min_sleep_threshold = '0;

   task_table_checker table_model = new();
   bit                jitter_on = 1'b1;
   int                rsp_hold = 0;
   int                threshold_writes = 0;

   software_timer_task_table_top i_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_type                (req_type),
      .req_task_id             (req_task_id),
      .req_timeout_value       (req_timeout_value),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_result_kind         (rsp_result_kind),
      .rsp_slot_index          (rsp_slot_index),
      .rsp_table_full          (rsp_table_full),
      .rsp_fired_id            (rsp_fired_id),
      .rsp_result_value        (rsp_result_value),
      .rsp_last                (rsp_last),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_min_sleep_threshold (csr_min_sleep_threshold)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sample every handshake at the edge; check responses before noting new requests.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            table_model.check_word(rsp_result_kind, rsp_slot_index, rsp_table_full,
                                   rsp_fired_id, rsp_result_value, rsp_last);
         if (req_valid && req_ready)
            table_model.note_request(req_type, req_task_id, req_timeout_value);
         if (csr_valid && csr_ready)
            table_model.threshold = csr_min_sleep_threshold;
      end
   end

   // Receiver: drop rsp_ready at random in bursts while jitter_on is set.
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else if (jitter_on && $urandom_range(0, 5) == 0) begin
         rsp_hold = $urandom_range(0, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Leave req_valid high on return so back-to-back words need no extra edge.
   task automatic send_request(input stt_pkg::req_code_type op,
                               input stt_pkg::id_port_type id,
                               input stt_pkg::time_type tmo);
      int gap = 0;
      if (jitter_on && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= op;
      req_task_id       <= id;
      req_timeout_value <= tmo;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop the request, then wait for every owed word and let the walk settle.
   task automatic drain_table();
      req_valid <= 1'b0;
      @(posedge clock);
      while (table_model.expected_words.size() != 0) @(posedge clock);
      repeat (WALK_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input stt_pkg::time_type value);
      csr_valid               <= 1'b1;
      csr_min_sleep_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      threshold_writes++;
   endtask

   function automatic stt_pkg::id_port_type pick_task();
      if ($urandom_range(0, 6) == 0)
         return stt_pkg::id_port_type'($urandom);
      return stt_pkg::id_port_type'($urandom_range(0, ID_POOL - 1));
   endfunction

   // Mostly short timeouts so ticks fire often; some wide values and exact 64K multiples.
   function automatic stt_pkg::time_type pick_timeout();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 10)
         return stt_pkg::time_type'($urandom_range(0, 40));
      if (pick < 13)
         return stt_pkg::time_type'($urandom_range(0, 16'hFFFF));
      if (pick < 15)
         return WRAP_STEP * $urandom_range(1, 3);
      if (pick < 18)
         return stt_pkg::time_type'($urandom);
      if (pick == 18)
         return stt_pkg::ALL_ONES - $urandom_range(0, 3);
      return '0;
   endfunction

   task automatic run_random(input int count);
      int                    pick;
      stt_pkg::req_code_type op;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 28)
            op = stt_pkg::REQ_ADD;
         else if (pick < 42)
            op = stt_pkg::REQ_INSERT;
         else if (pick < 66)
            op = stt_pkg::REQ_TICK;
         else if (pick < 78)
            op = stt_pkg::REQ_DELETE;
         else if (pick < 94)
            op = stt_pkg::REQ_QUERY;
         else
            op = stt_pkg::req_code_type'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
         send_request(op, pick_task(), pick_timeout());
      end
   endtask

   task automatic run_directed();
      // insert with no window open, then query hit and miss
      send_request(stt_pkg::REQ_INSERT, 8'd3, stt_pkg::time_type'(20));
      send_request(stt_pkg::REQ_QUERY, 8'd3, '0);
      send_request(stt_pkg::REQ_QUERY, 8'd200, stt_pkg::ALL_ONES);
      // first tick counts down, second fires and leaves an empty table
      send_request(stt_pkg::REQ_TICK, '0, '0);
      send_request(stt_pkg::REQ_TICK, '1, stt_pkg::ALL_ONES);
      send_request(stt_pkg::REQ_ADD, '0, '0);
      send_request(stt_pkg::REQ_ADD, '1, stt_pkg::ALL_ONES);
      send_request(stt_pkg::REQ_ADD, '0, stt_pkg::time_type'(7));
      for (int k = 0; k < stt_pkg::SLOTS - 2; k++)
         send_request(stt_pkg::REQ_ADD, stt_pkg::id_port_type'(10 + k),
                      stt_pkg::time_type'(100 + k));
      send_request(stt_pkg::REQ_ADD, 8'd99, stt_pkg::time_type'(9));
      // full table, but the same id frees its own slot
      send_request(stt_pkg::REQ_ADD, '1, stt_pkg::time_type'(5));
      // insert inside the window on a full table
      send_request(stt_pkg::REQ_INSERT, 8'd42, stt_pkg::time_type'(30));
      send_request(stt_pkg::REQ_DELETE, 8'd10, '0);
      send_request(stt_pkg::REQ_INSERT, 8'd42, stt_pkg::time_type'(3));
      send_request(stt_pkg::REQ_DELETE, 8'd11, '0);
      send_request(stt_pkg::REQ_INSERT, 8'd43, '0);
      send_request(stt_pkg::REQ_DELETE, 8'd12, '0);
      send_request(stt_pkg::REQ_INSERT, 8'd44, stt_pkg::time_type'(25));
      for (int c = REQ_UNUSED_FIRST; c <= REQ_UNUSED_LAST; c++)
         send_request(stt_pkg::req_code_type'(c), stt_pkg::id_port_type'($urandom),
                      stt_pkg::time_type'($urandom));
      send_request(stt_pkg::REQ_TICK, '0, '0);
      send_request(stt_pkg::REQ_TICK, '0, '0);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      drain_table();
      write_threshold(stt_pkg::time_type'(12));
      run_random(40);
      drain_table();
      write_threshold(stt_pkg::ALL_ONES);
      run_random(30);
      drain_table();
      write_threshold(stt_pkg::time_type'($urandom_range(1, 16'hFFFF)));
      run_random(40);
      drain_table();
      write_threshold(stt_pkg::time_type'($urandom));
      run_random(25);
      drain_table();
      write_threshold('0);
      run_random(40);
      drain_table();
      // final stretch runs at full rate on both sides
      jitter_on = 1'b0;
      write_threshold(stt_pkg::time_type'(3));
      run_random(30);
      drain_table();
      $display("Ran %0d requests, checked %0d response words (%0d fired tasks, %0d full table)",
               table_model.requests_seen, table_model.words_seen, table_model.fired_seen,
               table_model.full_seen);
      $display("Threshold set %0d times from zero to all ones; %0d mismatches",
               threshold_writes, table_model.errors);
      if (table_model.errors == 0 && table_model.expected_words.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
